// File: design/register_write_serial_framer_macros.svh
// Assertion helpers used by the framer sequencer (rwsf_seq)
`ifndef REGISTER_WRITE_SERIAL_FRAMER_MACROS_SVH
`define REGISTER_WRITE_SERIAL_FRAMER_MACROS_SVH

// Checked only outside reset
`define RWSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define RWSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/rwsf_pkg.sv
package rwsf_pkg;

    // Command codes
    localparam logic [1:0] CMD_REG_WRITE     = 2'd0;
    localparam logic [1:0] CMD_RESET_ASSERT  = 2'd1;
    localparam logic [1:0] CMD_RESET_RELEASE = 2'd2;
    localparam logic [1:0] CMD_UNUSED        = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BOARD_ADDRESS = 1'b0;
    localparam logic CFG_ENABLE        = 1'b1;

    localparam logic [7:0] BOARD_RESET = 8'h42;

    // Packet bytes
    localparam logic [7:0] PKT_HEADER  = 8'h12;
    localparam logic [7:0] PKT_REG_P0  = 8'he1;
    localparam logic [7:0] PKT_VAL_P0  = 8'he3;
    localparam logic [7:0] PKT_REG_P1  = 8'he5;
    localparam logic [7:0] PKT_VAL_P1  = 8'he7;
    localparam logic [7:0] PKT_TRAILER = 8'hfb;
    localparam logic [7:0] PKT_RST_ON  = 8'hfe;
    localparam logic [7:0] PKT_RST_OFF = 8'hff;

    // Frame bytes
    localparam logic [7:0] FRAME_START = 8'h00;
    localparam logic [7:0] FRAME_END   = 8'h02;

    // Packet shift register and 7-bit group handling
    localparam int PKT_BITS   = 64;
    localparam int GROUP_BITS = 7;
    localparam int CNT_W      = 4;
    localparam logic [CNT_W-1:0] GROUPS_WRITE = 4'd10; // 64 bits -> 10 groups
    localparam logic [CNT_W-1:0] GROUPS_RESET = 4'd4;  // 24 bits -> 4 groups

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SOF,
        ST_DATA,
        ST_EOF
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic       port;
        logic [7:0] reg_addr;
        logic [7:0] value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       last_byte;
    } out_word_t;

    // Sequencer commands to the shift unit
    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctrl_t;

endpackage

// File: design/register_write_serial_framer.sv
// Channel   Direction  Payload                          Handshake
// s_        in         command, port, reg_addr, value   s_valid / s_ready
// m_        out        wire_byte, last_byte             m_valid / m_ready
// cfg_      in         board_address, enable            cfg_wr_en (no wait)
//
// A command is taken while idle, then its frame goes out one word per cycle
// while m_ready is high: 12 words for a register write, 6 for a reset
// command. The 64-bit packet shift register and its group counter set this:
// one 7-bit group leaves per data word.
// A disabled or unused command is taken and dropped; the block stays idle.
// Output stalls hold the current word; no input is taken until the frame ends.
// Reset (aresetn low, synchronous) returns to idle, board 0x42, disabled.
module register_write_serial_framer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rwsf_pkg::in_word_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rwsf_pkg::out_word_t   m_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_wdata
);

    logic [7:0]                       board_reg;
    logic                             enable_reg;
    rwsf_pkg::state_t                 state;
    rwsf_pkg::shift_ctrl_t            ctrl;
    logic [rwsf_pkg::GROUP_BITS-1:0]  group_bits;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_reg  <= rwsf_pkg::BOARD_RESET;
            enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            if (cfg_index == rwsf_pkg::CFG_BOARD_ADDRESS) board_reg <= cfg_wdata;
            if (cfg_index == rwsf_pkg::CFG_ENABLE)        enable_reg <= cfg_wdata[0];
        end
    end

    rwsf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .command (s_data.command),
        .enable  (enable_reg),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .state   (state),
        .ctrl    (ctrl)
    );

    rwsf_shift u_shift (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .item       (s_data),
        .board      (board_reg),
        .group_bits (group_bits)
    );

    // Output word by frame position
    always_comb begin
        m_data.wire_byte = rwsf_pkg::FRAME_START;
        m_data.last_byte = 1'b0;
        case (state)
            rwsf_pkg::ST_SOF:  m_data.wire_byte = rwsf_pkg::FRAME_START;
            rwsf_pkg::ST_DATA: m_data.wire_byte = {group_bits, 1'b1};
            rwsf_pkg::ST_EOF: begin
                m_data.wire_byte = rwsf_pkg::FRAME_END;
                m_data.last_byte = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// File: design/rwsf_shift.sv
module rwsf_shift (
    input  logic                                aclk,
    input  rwsf_pkg::shift_ctrl_t               ctrl,
    input  rwsf_pkg::in_word_t                  item,
    input  logic [7:0]                          board,
    output logic [rwsf_pkg::GROUP_BITS-1:0]     group_bits
);

    logic [rwsf_pkg::PKT_BITS-1:0] sr_reg;
    logic [rwsf_pkg::PKT_BITS-1:0] sr_next;
    logic [rwsf_pkg::PKT_BITS-1:0] packet;

    // Logical packet, left aligned; short packets are zero padded
    always_comb begin
        if (item.command == rwsf_pkg::CMD_REG_WRITE) begin
            packet = {board, rwsf_pkg::PKT_HEADER,
                      item.port ? rwsf_pkg::PKT_REG_P1 : rwsf_pkg::PKT_REG_P0,
                      item.reg_addr,
                      item.port ? rwsf_pkg::PKT_VAL_P1 : rwsf_pkg::PKT_VAL_P0,
                      item.value, rwsf_pkg::PKT_TRAILER, item.value};
        end else begin
            packet = {board, rwsf_pkg::PKT_HEADER,
                      (item.command == rwsf_pkg::CMD_RESET_ASSERT) ?
                          rwsf_pkg::PKT_RST_ON : rwsf_pkg::PKT_RST_OFF,
                      40'd0};
        end
    end

    // Load, or shift one 7-bit group out of the top
    always_comb begin
        sr_next = sr_reg;
        if (ctrl.load) begin
            sr_next = packet;
        end else if (ctrl.shift) begin
            sr_next = {sr_reg[rwsf_pkg::PKT_BITS-rwsf_pkg::GROUP_BITS-1:0],
                       {rwsf_pkg::GROUP_BITS{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg <= sr_next;
    end

    assign group_bits = sr_reg[rwsf_pkg::PKT_BITS-1 -: rwsf_pkg::GROUP_BITS];

endmodule

// File: design/rwsf_seq.sv
`include "register_write_serial_framer_macros.svh"

module rwsf_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic [1:0]              command,
    input  logic                    enable,
    input  logic                    m_ready,
    output logic                    s_ready,
    output logic                    m_valid,
    output rwsf_pkg::state_t        state,
    output rwsf_pkg::shift_ctrl_t   ctrl
);

    rwsf_pkg::state_t              state_reg;
    rwsf_pkg::state_t              state_next;
    logic [rwsf_pkg::CNT_W-1:0]    count_reg;
    logic [rwsf_pkg::CNT_W-1:0]    count_next;
    logic                          accept;
    logic                          emit;

    assign accept = s_valid && s_ready;
    assign emit   = enable && (command != rwsf_pkg::CMD_UNUSED);

    // Next state and group count
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            rwsf_pkg::ST_IDLE: begin
                if (s_valid && emit) begin
                    state_next = rwsf_pkg::ST_SOF;
                    count_next = (command == rwsf_pkg::CMD_REG_WRITE) ?
                                 rwsf_pkg::GROUPS_WRITE : rwsf_pkg::GROUPS_RESET;
                end
            end
            rwsf_pkg::ST_SOF: begin
                if (m_ready) state_next = rwsf_pkg::ST_DATA;
            end
            rwsf_pkg::ST_DATA: begin
                if (m_ready) begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == 1) state_next = rwsf_pkg::ST_EOF;
                end
            end
            rwsf_pkg::ST_EOF: begin
                if (m_ready) state_next = rwsf_pkg::ST_IDLE;
            end
            default: state_next = rwsf_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.shift = 1'b0;
        case (state_reg)
            rwsf_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
            end
            rwsf_pkg::ST_SOF:  m_valid = 1'b1;
            rwsf_pkg::ST_DATA: begin
                m_valid    = 1'b1;
                ctrl.shift = m_ready;
            end
            rwsf_pkg::ST_EOF:  m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rwsf_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign state = state_reg;

    `RWSF_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == rwsf_pkg::ST_IDLE, "not idle after reset")
    `RWSF_ASSERT(a_data_count, aclk, aresetn, state_reg == rwsf_pkg::ST_DATA |-> count_reg != 0, "data state with zero groups left")
    `RWSF_ASSERT(a_start_frame, aclk, aresetn, accept && emit |=> state_reg == rwsf_pkg::ST_SOF, "enabled command did not start a frame")
    `RWSF_ASSERT(a_drop, aclk, aresetn, accept && !emit |=> state_reg == rwsf_pkg::ST_IDLE, "dropped command started a frame")
    `RWSF_ASSERT(a_group_load, aclk, aresetn, state_reg == rwsf_pkg::ST_SOF && m_ready |=> state_reg == rwsf_pkg::ST_DATA && (count_reg == rwsf_pkg::GROUPS_WRITE || count_reg == rwsf_pkg::GROUPS_RESET), "bad group count at frame data")

endmodule

// File: dv/rwsf_frame_checker.sv
module rwsf_frame_checker
    import rwsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  in_word_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  out_word_t  m_data,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    output int         fail_count,
    output int         words_due,
    output int         words_checked
);

    // Shadow copy of the two registers
    logic [7:0] board_q;
    logic       enable_q;

    // Wire words still owed by the block, oldest first
    out_word_t  frame_words_due[$];

    // Cut the packet of one command into the wire frame and queue its words
    function automatic void append_frame(in_word_t cmd);
        logic [63:0] packet;
        logic [69:0] bits;
        int          nbits;
        int          groups;
        out_word_t   w;
        if (!enable_q || cmd.command == CMD_UNUSED) return;
        if (cmd.command == CMD_REG_WRITE) begin
            packet = {board_q, PKT_HEADER, cmd.port ? PKT_REG_P1 : PKT_REG_P0, cmd.reg_addr,
                      cmd.port ? PKT_VAL_P1 : PKT_VAL_P0, cmd.value, PKT_TRAILER, cmd.value};
            nbits  = 64;
        end else begin
            packet = {board_q, PKT_HEADER,
                      (cmd.command == CMD_RESET_ASSERT) ? PKT_RST_ON : PKT_RST_OFF, 40'd0};
            nbits  = 24;
        end
        groups = (nbits + 6) / 7;
        // zero pad below the packet so the last short group reads clean zeros
        bits = {packet, 6'd0};
        w.wire_byte = FRAME_START;
        w.last_byte = 1'b0;
        frame_words_due.push_back(w);
        for (int g = 0; g < groups; g++) begin
            w.wire_byte = {bits[69 - 7*g -: 7], 1'b1};
            frame_words_due.push_back(w);
        end
        w.wire_byte = FRAME_END;
        w.last_byte = 1'b1;
        frame_words_due.push_back(w);
    endfunction

    // Watch both channels and the register port
    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            board_q  = BOARD_RESET;
            enable_q = 1'b0;
            frame_words_due.delete();
            fail_count    = 0;
            words_checked = 0;
        end else begin
            if (s_valid && s_ready) append_frame(s_data);

            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t: unexpected word: expected none, got byte %02h last %0b",
                                 $time, m_data.wire_byte, m_data.last_byte);
                end else begin
                    want = frame_words_due.pop_front();
                    words_checked++;
                    if (m_data.wire_byte !== want.wire_byte) begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t: wire_byte mismatch: expected %02h, got %02h",
                                     $time, want.wire_byte, m_data.wire_byte);
                    end
                    if (m_data.last_byte !== want.last_byte) begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t: last_byte mismatch: expected %0b, got %0b",
                                     $time, want.last_byte, m_data.last_byte);
                    end
                end
            end

            // the bench writes only while idle, so order against traffic is moot
            if (cfg_wr_en) begin
                if (cfg_index == CFG_BOARD_ADDRESS) board_q = cfg_wdata;
                else                                enable_q = cfg_wdata[0];
            end
        end
        words_due = frame_words_due.size();
    end

endmodule

// File: dv/tb.sv
module tb;
    import rwsf_pkg::*;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_BOARD_ADDRESS;
    logic [7:0]  cfg_wdata = '0;

    int          fail_count;
    int          words_due;
    int          words_checked;

    logic        enabled_now   = 1'b0;
    int          framed_writes = 0;
    int          framed_resets = 0;
    int          dropped       = 0;

    logic [15:0] ready_pattern = 16'hffff;
    int          ready_age     = 0;

    register_write_serial_framer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rwsf_frame_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .words_due     (words_due),
        .words_checked (words_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #7200000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: rotate a stall pattern, reloading a new style now and then
    always @(posedge aclk) begin
        if (ready_age == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= 16'hffff;
                1: ready_pattern <= 16'($urandom());
                2: ready_pattern <= 16'h0001;
                default: ready_pattern <= 16'($urandom()) | 16'($urandom());
            endcase
            ready_age <= $urandom_range(50, 300);
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            ready_age <= ready_age - 1;
        end
        m_ready <= ready_pattern[0];
    end

    function automatic in_word_t make_cmd(logic [1:0] c, logic p, logic [7:0] r,
                                          logic [7:0] v);
        in_word_t w;
        w.command  = c;
        w.port     = p;
        w.reg_addr = r;
        w.value    = v;
        return w;
    endfunction

    // Mostly register writes, some reset commands, a few unused codes
    function automatic in_word_t random_cmd();
        int         pick;
        logic [1:0] c;
        pick = $urandom_range(0, 15);
        if (pick < 8)       c = CMD_REG_WRITE;
        else if (pick < 11) c = CMD_RESET_ASSERT;
        else if (pick < 14) c = CMD_RESET_RELEASE;
        else                c = CMD_UNUSED;
        return make_cmd(c, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endfunction

    task automatic write_reg(logic idx, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ENABLE) enabled_now = data[0];
        @(posedge aclk);
    endtask

    // Present one word and hold it until taken
    task automatic send_command(in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!enabled_now || w.command == CMD_UNUSED) dropped++;
        else if (w.command == CMD_REG_WRITE)         framed_writes++;
        else                                         framed_resets++;
    endtask

    // Drain every owed word, then give a dropped command time to clear
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Random commands in bursts with random gaps
    task automatic run_phase(int items, int gap_max);
        int burst;
        int gap;
        int left;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 10);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_command(random_cmd());
                left--;
            end
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    initial begin
        int         start_count;
        int         sel;
        logic       en;
        logic [7:0] board;
        int         gap_max;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Still disabled out of reset: these must vanish
        send_command(make_cmd(CMD_REG_WRITE, 1'b1, 8'hff, 8'hff));
        send_command(make_cmd(CMD_RESET_ASSERT, 1'b0, 8'h00, 8'h00));
        settle();

        // Enabled with the reset board address
        write_reg(CFG_ENABLE, 8'h01);
        send_command(make_cmd(CMD_REG_WRITE, 1'b0, 8'h00, 8'h00));
        send_command(make_cmd(CMD_REG_WRITE, 1'b1, 8'hff, 8'hff));
        send_command(make_cmd(CMD_REG_WRITE, 1'b0, 8'haa, 8'h55));
        send_command(make_cmd(CMD_REG_WRITE, 1'b1, 8'h55, 8'haa));
        send_command(make_cmd(CMD_RESET_ASSERT, 1'b0, 8'h00, 8'h00));
        send_command(make_cmd(CMD_RESET_RELEASE, 1'b1, 8'hff, 8'hff));
        send_command(make_cmd(CMD_UNUSED, 1'b1, 8'hff, 8'hff));
        send_command(make_cmd(CMD_REG_WRITE, 1'b0, 8'h01, 8'h80));
        send_command(make_cmd(CMD_UNUSED, 1'b0, 8'h00, 8'h00));
        send_command(make_cmd(CMD_REG_WRITE, 1'b1, 8'h80, 8'h01));
        settle();

        // Board address extremes
        write_reg(CFG_BOARD_ADDRESS, 8'h00);
        send_command(make_cmd(CMD_REG_WRITE, 1'b0, 8'h00, 8'h00));
        send_command(make_cmd(CMD_RESET_ASSERT, 1'b1, 8'h7f, 8'hfe));
        settle();
        write_reg(CFG_BOARD_ADDRESS, 8'hff);
        send_command(make_cmd(CMD_REG_WRITE, 1'b1, 8'hff, 8'hff));
        send_command(make_cmd(CMD_RESET_RELEASE, 1'b0, 8'h00, 8'h01));
        settle();

        // Random phases, each under a fresh register setting
        start_count = framed_writes + framed_resets;
        while (framed_writes + framed_resets - start_count < 330) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      board = 8'h00;
            else if (sel == 1) board = 8'hff;
            else               board = 8'($urandom_range(0, 255));
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            write_reg(CFG_BOARD_ADDRESS, board);
            write_reg(CFG_ENABLE, {7'd0, en});
            run_phase(en ? $urandom_range(20, 40) : 8, gap_max);
            settle();
        end
        repeat (20) @(posedge aclk);

        $display("Framed %0d register writes and %0d reset commands, %0d dropped",
                 framed_writes, framed_resets, dropped);
        $display("%0d wire words compared with predicted frames", words_checked);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
